// File: rtl/wsfr_pkg.sv
`timescale 1ns / 1ps

package wsfr_pkg;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
  localparam logic [2:0] MASK_BYTES_M1  = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // work handed from the parser to the unmasking side
  typedef struct packed {
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        fin;
    logic [63:0] frame_length;
    logic [31:0] key;
    logic [1:0]  offset;
    logic        empty;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic        fin;
    logic [63:0] frame_length;
    logic        is_empty;
    logic        last_of_frame;
  } res_t;

endpackage

// File: rtl/websocket_frame_receiver_top.sv
`timescale 1ns / 1ps

// WebSocket frame receiver: takes one raw stream byte per cycle while full is
// low and returns the unmasked payload bytes of each frame, with opcode, FIN
// and decoded length alongside, the final byte marked; a frame of zero length
// gives a single empty result. Header bytes give no result. Sustained rate is
// one byte per cycle while results are popped. A payload byte passes the
// combinational parser and is registered first in the request queue and then
// in the result queue before it shows on the result ports. full rises only
// when both internal queues have backed up.

module websocket_frame_receiver_top #(
  parameter int CMD_DEPTH = wsfr_pkg::CMD_QUEUE_DEPTH,
  parameter int RES_DEPTH = wsfr_pkg::RES_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  payload_byte,
  output logic [3:0]  opcode,
  output logic        fin,
  output logic [63:0] frame_length,
  output logic        is_empty,
  output logic        last_of_frame
);

  import wsfr_pkg::*;

  logic                    byte_valid;
  logic                    front_valid;
  cmd_t                    front_cmd;
  logic                    cmd_full;
  logic                    cmd_empty;
  logic [$bits(cmd_t)-1:0] cmd_bits;
  cmd_t                    back_cmd;
  logic                    cmd_pop;
  logic                    res_valid;
  res_t                    res;

  assign full       = cmd_full;
  assign byte_valid = push && !cmd_full;
  assign back_cmd   = cmd_t'(cmd_bits);

  wsfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .stream_byte (stream_byte),
    .cmd_valid   (front_valid),
    .cmd         (front_cmd)
  );

  wsfr_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_valid),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_bits),
    .empty   (cmd_empty)
  );

  wsfr_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res       (res)
  );

  assign empty         = !res_valid;
  assign payload_byte  = res.payload_byte;
  assign opcode        = res.opcode;
  assign fin           = res.fin;
  assign frame_length  = res.frame_length;
  assign is_empty      = res.is_empty;
  assign last_of_frame = res.last_of_frame;

endmodule

// File: rtl/wsfr_queue.sv
`timescale 1ns / 1ps

module wsfr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue lost a request");

endmodule

// File: rtl/wsfr_front.sv
`timescale 1ns / 1ps

module wsfr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  input  logic [7:0]     stream_byte,
  output logic           cmd_valid,
  output wsfr_pkg::cmd_t cmd
);

  import wsfr_pkg::*;

  phase_t      phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask_present, mask_present_next;
  logic [63:0] length, length_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [31:0] key, key_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  offset, offset_next;

  logic [6:0]  code;
  logic [63:0] len_shift;
  logic        is_ext;
  logic        run_done;
  logic        pay_last;

  assign code      = stream_byte[6:0];
  assign len_shift = {length[55:0], stream_byte};
  assign is_ext    = (code == LEN_CODE_EXT16) || (code == LEN_CODE_EXT64);
  assign run_done  = (hdr_cnt == '0);
  assign pay_last  = (remaining == 64'd1);

  // next phase
  always_comb begin
    phase_next = phase;
    if (byte_valid) begin
      case (phase)
        PH_HDR1: begin
          if (is_ext) begin
            phase_next = PH_EXTLEN;
          end else if (stream_byte[7]) begin
            phase_next = PH_MASK;
          end else if (code == '0) begin
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_EXTLEN: begin
          if (run_done) begin
            if (mask_present) begin
              phase_next = PH_MASK;
            end else if (len_shift == '0) begin
              phase_next = PH_HDR0;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_MASK: begin
          if (run_done) begin
            phase_next = (length == '0) ? PH_HDR0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR1;
        end
      endcase
    end
  end

  // frame context
  always_comb begin
    fin_next          = fin;
    opcode_next       = opcode;
    mask_present_next = mask_present;
    length_next       = length;
    hdr_cnt_next      = hdr_cnt;
    key_next          = key;
    remaining_next    = remaining;
    offset_next       = offset;
    if (byte_valid) begin
      case (phase)
        PH_HDR1: begin
          mask_present_next = stream_byte[7];
          key_next          = '0;
          if (code == LEN_CODE_EXT16) begin
            length_next  = '0;
            hdr_cnt_next = EXT16_BYTES_M1;
          end else if (code == LEN_CODE_EXT64) begin
            length_next  = '0;
            hdr_cnt_next = EXT64_BYTES_M1;
          end else begin
            length_next = {57'd0, code};
            if (stream_byte[7]) begin
              hdr_cnt_next = MASK_BYTES_M1;
            end else begin
              remaining_next = {57'd0, code};
              offset_next    = '0;
            end
          end
        end
        PH_EXTLEN: begin
          length_next = len_shift;
          if (run_done) begin
            if (mask_present) begin
              hdr_cnt_next = MASK_BYTES_M1;
              key_next     = '0;
            end else begin
              remaining_next = len_shift;
              offset_next    = '0;
            end
          end else begin
            hdr_cnt_next = hdr_cnt - 3'd1;
          end
        end
        PH_MASK: begin
          key_next = {key[23:0], stream_byte};
          if (run_done) begin
            remaining_next = length;
            offset_next    = '0;
          end else begin
            hdr_cnt_next = hdr_cnt - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          remaining_next = remaining - 64'd1;
          offset_next    = offset + 2'd1;
        end
        default: begin
          fin_next     = stream_byte[7];
          opcode_next  = stream_byte[3:0];
          hdr_cnt_next = '0;
        end
      endcase
    end
  end

  // requests to the back end
  always_comb begin
    cmd_valid        = 1'b0;
    cmd.data         = stream_byte;
    cmd.opcode       = opcode;
    cmd.fin          = fin;
    cmd.frame_length = length_next;
    cmd.key          = key;
    cmd.offset       = offset;
    cmd.empty        = 1'b0;
    cmd.last         = 1'b0;
    if (byte_valid) begin
      case (phase)
        PH_HDR1: begin
          cmd.empty = 1'b1;
          cmd_valid = !is_ext && !stream_byte[7] && (code == '0);
        end
        PH_EXTLEN: begin
          cmd.empty = 1'b1;
          cmd_valid = run_done && !mask_present && (len_shift == '0);
        end
        PH_MASK: begin
          cmd.empty = 1'b1;
          cmd_valid = run_done && (length == '0);
        end
        PH_PAYLOAD: begin
          cmd_valid = 1'b1;
          cmd.last  = pay_last;
        end
        default: begin
          cmd_valid = 1'b0;
        end
      endcase
    end
    if (cmd.empty) begin
      cmd.data = '0;
      cmd.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      fin          <= 1'b0;
      opcode       <= '0;
      mask_present <= 1'b0;
      length       <= '0;
      hdr_cnt      <= '0;
      key          <= '0;
      remaining    <= '0;
      offset       <= '0;
    end else begin
      phase        <= phase_next;
      fin          <= fin_next;
      opcode       <= opcode_next;
      mask_present <= mask_present_next;
      length       <= length_next;
      hdr_cnt      <= hdr_cnt_next;
      key          <= key_next;
      remaining    <= remaining_next;
      offset       <= offset_next;
    end
  end

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining != '0))
    else $error("payload phase with nothing left");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && cmd_valid && cmd.last) |=> (phase == PH_HDR0))
    else $error("frame end did not return to header");

endmodule

// File: rtl/wsfr_back.sv
`timescale 1ns / 1ps

module wsfr_back #(
  parameter int RES_DEPTH = wsfr_pkg::RES_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  wsfr_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  input  logic           res_pop,
  output wsfr_pkg::res_t res
);

  import wsfr_pkg::*;

  logic [7:0]              key_byte;
  res_t                    res_in;
  logic                    res_full;
  logic                    res_empty;
  logic [$bits(res_t)-1:0] res_bits;

  always_comb begin
    case (cmd.offset)
      2'd0:    key_byte = cmd.key[31:24];
      2'd1:    key_byte = cmd.key[23:16];
      2'd2:    key_byte = cmd.key[15:8];
      default: key_byte = cmd.key[7:0];
    endcase
  end

  always_comb begin
    res_in.payload_byte  = cmd.empty ? 8'd0 : (cmd.data ^ key_byte);
    res_in.opcode        = cmd.opcode;
    res_in.fin           = cmd.fin;
    res_in.frame_length  = cmd.frame_length;
    res_in.is_empty      = cmd.empty;
    res_in.last_of_frame = cmd.last;
  end

  assign cmd_pop   = cmd_valid && !res_full;
  assign res_valid = !res_empty;
  assign res       = res_t'(res_bits);

  wsfr_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_pop),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (res_pop),
    .rd_data (res_bits),
    .empty   (res_empty)
  );

endmodule

// File: test/websocket_frame_receiver_checker.sv
`timescale 1ns / 1ps

module websocket_frame_receiver_checker
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  stream_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  payload_byte,
  input  logic [3:0]  opcode,
  input  logic        fin,
  input  logic [63:0] frame_length,
  input  logic        is_empty,
  input  logic        last_of_frame,
  output int          fail_count,
  output int          pending
);

  localparam int REPORT_LINES = 20;

  // deframer state as the block should hold it
  phase_t      phase;
  logic        fin_q;
  logic [3:0]  opc_q;
  logic        mask_q;
  logic [63:0] len_q;
  logic [2:0]  hdr_left;
  logic [31:0] key_q;
  logic [63:0] offset_q;

  res_t awaited_results[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < REPORT_LINES)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic res_t frame_result(input logic [7:0] data, input logic no_data,
                                        input logic last);
    res_t r;
    r.payload_byte  = data;
    r.opcode        = opc_q;
    r.fin           = fin_q;
    r.frame_length  = len_q;
    r.is_empty      = no_data;
    r.last_of_frame = last;
    return r;
  endfunction

  task automatic close_header();
    offset_q = '0;
    if (len_q == 64'd0) begin
      awaited_results.push_back(frame_result(8'h00, 1'b1, 1'b1));
      phase = PH_HDR0;
    end else begin
      phase = PH_PAYLOAD;
    end
  endtask

  task automatic close_length();
    if (mask_q) begin
      hdr_left = MASK_BYTES_M1;
      key_q    = '0;
      phase    = PH_MASK;
    end else begin
      close_header();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] k;
    int         sh;
    case (phase)
      PH_HDR1: begin
        mask_q = b[7];
        key_q  = '0;
        len_q  = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          hdr_left = EXT16_BYTES_M1;
          phase    = PH_EXTLEN;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          hdr_left = EXT64_BYTES_M1;
          phase    = PH_EXTLEN;
        end else begin
          len_q = {57'd0, b[6:0]};
          close_length();
        end
      end
      PH_EXTLEN: begin
        len_q = {len_q[55:0], b};
        if (hdr_left == 3'd0) close_length();
        else hdr_left--;
      end
      PH_MASK: begin
        key_q = {key_q[23:0], b};
        if (hdr_left == 3'd0) close_header();
        else hdr_left--;
      end
      PH_PAYLOAD: begin
        // key byte 0 sits in the top bits
        sh = 24 - 8 * int'(offset_q[1:0]);
        k  = mask_q ? 8'(key_q >> sh) : 8'h00;
        if (offset_q == len_q - 64'd1) begin
          awaited_results.push_back(frame_result(b ^ k, 1'b0, 1'b1));
          phase    = PH_HDR0;
          offset_q = '0;
        end else begin
          awaited_results.push_back(frame_result(b ^ k, 1'b0, 1'b0));
          offset_q++;
        end
      end
      default: begin
        fin_q    = b[7];
        opc_q    = b[3:0];
        hdr_left = '0;
        phase    = PH_HDR1;
      end
    endcase
  endtask

  task automatic check_result();
    res_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with no request outstanding", 64'(payload_byte), 64'd0);
    end else begin
      want = awaited_results.pop_front();
      if (payload_byte !== want.payload_byte)
        report_mismatch("payload_byte", 64'(payload_byte), 64'(want.payload_byte));
      if (opcode !== want.opcode)
        report_mismatch("opcode", 64'(opcode), 64'(want.opcode));
      if (fin !== want.fin)
        report_mismatch("fin", 64'(fin), 64'(want.fin));
      if (frame_length !== want.frame_length)
        report_mismatch("frame_length", frame_length, want.frame_length);
      if (is_empty !== want.is_empty)
        report_mismatch("is_empty", 64'(is_empty), 64'(want.is_empty));
      if (last_of_frame !== want.last_of_frame)
        report_mismatch("last_of_frame", 64'(last_of_frame), 64'(want.last_of_frame));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase      = PH_HDR0;
      fin_q      = 1'b0;
      opc_q      = '0;
      mask_q     = 1'b0;
      len_q      = '0;
      hdr_left   = '0;
      key_q      = '0;
      offset_q   = '0;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      if (pop && !empty) check_result();
      if (push && !full) deframe_byte(stream_byte);
    end
    pending <= awaited_results.size();
  end

endmodule

// File: test/tb_websocket_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_websocket_frame_receiver_top;
  import wsfr_pkg::*;

  localparam int STREAM_BYTES = 1850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;

  // empty frame; masked short frame with RSV bits set and FIN clear;
  // 16-bit length of zero; 64-bit length of one, unmasked
  localparam logic [7:0] DIRECTED_BYTES [26] = '{
    8'h81, 8'h00,
    8'h7A, 8'h83, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h0F, 8'h00,
    8'h80, 8'h7E, 8'h00, 8'h00,
    8'h0F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF
  };

  logic        clk;
  logic        rst         = 1'b1;
  logic        push        = 1'b0;
  logic [7:0]  stream_byte = 8'h00;
  logic        pop         = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  payload_byte;
  logic [3:0]  opcode;
  logic        fin;
  logic [63:0] frame_length;
  logic        is_empty;
  logic        last_of_frame;

  int fail_count;
  int pending;
  int bytes_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit holding     = 1'b0;

  websocket_frame_receiver_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .stream_byte  (stream_byte),
    .empty        (empty),
    .pop          (pop),
    .payload_byte (payload_byte),
    .opcode       (opcode),
    .fin          (fin),
    .frame_length (frame_length),
    .is_empty     (is_empty),
    .last_of_frame(last_of_frame)
  );

  websocket_frame_receiver_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .stream_byte  (stream_byte),
    .empty        (empty),
    .pop          (pop),
    .payload_byte (payload_byte),
    .opcode       (opcode),
    .fin          (fin),
    .frame_length (frame_length),
    .is_empty     (is_empty),
    .last_of_frame(last_of_frame),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      // keep offering while the receiver holds off so the block backs up
      if (holding) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(5, 20);
      else gap = $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 24);
      if (gap > 0) begin
        push        <= 1'b0;
        stream_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    push        <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (full);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic drain_results();
    push       <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_frame(input logic [7:0] b0, input logic masked,
                            input logic [6:0] code, input logic [63:0] len,
                            input logic [31:0] key, input int body_bytes);
    send_byte(b0);
    send_byte({masked, code});
    if (code == LEN_CODE_EXT16)
      for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    else if (code == LEN_CODE_EXT64)
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int n = 0; n < body_bytes; n++) send_byte(8'($urandom));
  endtask

  // result side: spans of differing pop density, one long hold-off
  initial begin
    int span;
    int mode;
    int rx_cycles;
    bit hold_done;
    rx_cycles = 0;
    hold_done = 1'b0;
    wait (!rst);
    forever begin
      span = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      repeat (span) begin
        if (!hold_done && rx_cycles >= HOLD_START) begin
          holding = 1'b1;
          pop     <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          rx_cycles += HOLD_CYCLES;
          holding   = 1'b0;
          hold_done = 1'b1;
        end
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 7) == 0);
          default: pop <= ((rx_cycles % 5) != 0);
        endcase
        @(posedge clk);
        rx_cycles++;
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          sel;
    logic [6:0]  code;
    logic [63:0] len;
    bit          mid_drained;
    mid_drained = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
    drain_results();

    while (bytes_sent < STREAM_BYTES) begin
      if (!mid_drained && bytes_sent >= STREAM_BYTES / 2) begin
        drain_results();
        mid_drained = 1'b1;
      end
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        len  = 64'($urandom_range(0, 12));
        code = len[6:0];
      end else if (sel < 14) begin
        len  = 64'($urandom_range(100, 125));
        code = len[6:0];
      end else if (sel < 17) begin
        // short lengths in the 16-bit form: non-minimal, zero included
        code = LEN_CODE_EXT16;
        len  = 64'($urandom_range(0, 40));
      end else if (sel < 19) begin
        code = LEN_CODE_EXT16;
        len  = 64'($urandom_range(126, 300));
      end else begin
        code = LEN_CODE_EXT64;
        len  = 64'($urandom_range(0, 20));
      end
      send_frame(8'($urandom), 1'($urandom_range(0, 1)), code, len, $urandom, int'(len));
    end

    // top length bit set: the frame can never finish, so it goes last
    send_frame(8'h82, 1'b1, LEN_CODE_EXT64, 64'h8012_3456_789A_BCDE, $urandom, 3);
    drain_results();
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
